// ===== sv/tsb_pkg.sv =====
// Shared types and constants of the bilinear texture sampler.
// No dependencies.
`timescale 1ns / 1ps

package tsb_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;
    localparam int SIZE_W     = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_MODE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 8'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] tex_width;
        logic [SIZE_W-1:0] tex_height;
        logic              address_mode;
        logic              filter_mode;
    } t_cfg;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_texel;

endpackage

// ===== sv/tsb_coord.sv =====
// Coordinate stages: address mode, scaling by texture size, texel indices.
// Depends on tsb_pkg.
`timescale 1ns / 1ps

module tsb_coord #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int COORD_FRAC_BITS = 16,
    parameter int XW              = 8,
    parameter int YW              = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic                       i_sample,
    input  tsb_pkg::t_texel            i_texel,
    input  logic signed [23:0]         i_u,
    input  logic signed [23:0]         i_v,
    input  tsb_pkg::t_cfg              i_cfg,
    output logic                       o_vld,
    output logic                       o_sample,
    output tsb_pkg::t_texel            o_texel,
    output logic [XW-1:0]              o_x0,
    output logic [XW-1:0]              o_x1,
    output logic [YW-1:0]              o_y0,
    output logic [YW-1:0]              o_y1,
    output logic [COORD_FRAC_BITS-1:0] o_dx,
    output logic [COORD_FRAC_BITS-1:0] o_dy
);
    import tsb_pkg::*;

    localparam int CF = COORD_FRAC_BITS;
    localparam int UW = CF + 1;
    localparam int SW = UW + SIZE_W;
    localparam logic signed [25:0] ONE_S = 26'sd1 <<< CF;
    localparam logic [SW:0] HALF = (SW+1)'(1) << (CF - 1);

    function automatic logic [UW-1:0] addr_map(input logic signed [23:0] c, input logic rep);
        logic signed [25:0] ce;
        logic [UW-1:0] res;
        ce = 26'(c);
        if (rep) begin
            res = {1'b0, ce[CF-1:0]};
        end else if (ce < 26'sd0) begin
            res = '0;
        end else if (ce > ONE_S) begin
            res = ONE_S[CF:0];
        end else begin
            res = ce[CF:0];
        end
        return res;
    endfunction

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s, input int mx);
        logic [31:0] s32;
        logic [31:0] r;
        s32 = 32'(s);
        if (s32 == 32'd0) begin
            r = 32'd1;
        end else if (s32 > 32'(mx)) begin
            r = 32'(mx);
        end else begin
            r = s32;
        end
        return r[SIZE_W-1:0];
    endfunction

    // returns {idx0, idx1, frac}
    function automatic logic [64+CF-1:0] index_of(input logic [SW-1:0] s,
                                                 input logic [SIZE_W-1:0] sz,
                                                 input logic bilin);
        logic [31:0] lim;
        logic [31:0] p;
        logic [31:0] p1;
        logic [SW:0] rs;
        logic [CF-1:0] f;
        lim = 32'(sz) - 32'd1;
        if (bilin) begin
            p = 32'(s >> CF);
            f = s[CF-1:0];
            if (p > lim) begin
                p = lim;
                f = '0;
            end
            p1 = (p + 32'd1 > lim) ? 32'd0 : p + 32'd1;
        end else begin
            rs = (SW+1)'(s) + HALF;
            p  = 32'(rs >> CF);
            if (p > lim) begin
                p = lim;
            end
            p1 = p;
            f  = '0;
        end
        return {p, p1, f};
    endfunction

    logic            r_a_vld, r_a_smp;
    t_texel          r_a_texel;
    logic [UW-1:0]   r_a_u, r_a_v;
    logic [SIZE_W-1:0] r_a_w, r_a_h;
    logic            r_a_fm;

    logic            r_b_vld, r_b_smp;
    t_texel          r_b_texel;
    logic [SW-1:0]   r_b_su, r_b_sv;
    logic [SIZE_W-1:0] r_b_w, r_b_h;
    logic            r_b_fm;

    logic [64+CF-1:0] xi, yi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_smp   <= i_sample;
            r_a_texel <= i_texel;
            r_a_u     <= addr_map(i_u, i_cfg.address_mode);
            r_a_v     <= addr_map(i_v, i_cfg.address_mode);
            r_a_w     <= eff_size(i_cfg.tex_width, MAX_WIDTH);
            r_a_h     <= eff_size(i_cfg.tex_height, MAX_HEIGHT);
            r_a_fm    <= i_cfg.filter_mode;
            r_b_smp   <= r_a_smp;
            r_b_texel <= r_a_texel;
            r_b_su    <= SW'(r_a_u) * SW'(r_a_w);
            r_b_sv    <= SW'(r_a_v) * SW'(r_a_h);
            r_b_w     <= r_a_w;
            r_b_h     <= r_a_h;
            r_b_fm    <= r_a_fm;
        end
    end

    always_comb begin
        xi = index_of(r_b_su, r_b_w, r_b_fm);
        yi = index_of(r_b_sv, r_b_h, r_b_fm);
    end

    assign o_vld    = r_b_vld;
    assign o_sample = r_b_smp;
    assign o_texel  = r_b_texel;
    assign o_x0     = xi[32+CF +: XW];
    assign o_x1     = xi[CF +: XW];
    assign o_dx     = xi[CF-1:0];
    assign o_y0     = yi[32+CF +: YW];
    assign o_y1     = yi[CF +: YW];
    assign o_dy     = yi[CF-1:0];

endmodule

// ===== sv/tsb_store.sv =====
// Texel store: two copies of the texture, each with two read ports.
// Depends on tsb_pkg.
`timescale 1ns / 1ps

module tsb_store #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int COORD_FRAC_BITS = 16,
    parameter int XW              = 8,
    parameter int YW              = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic                       i_sample,
    input  tsb_pkg::t_texel            i_texel,
    input  logic [XW-1:0]              i_x0,
    input  logic [XW-1:0]              i_x1,
    input  logic [YW-1:0]              i_y0,
    input  logic [YW-1:0]              i_y1,
    input  logic [COORD_FRAC_BITS-1:0] i_dx,
    input  logic [COORD_FRAC_BITS-1:0] i_dy,
    output logic                       o_vld,
    output logic                       o_sample,
    output logic [23:0]                o_t00,
    output logic [23:0]                o_t10,
    output logic [23:0]                o_t01,
    output logic [23:0]                o_t11,
    output logic [COORD_FRAC_BITS-1:0] o_dx,
    output logic [COORD_FRAC_BITS-1:0] o_dy
);
    import tsb_pkg::*;

    localparam int AW = XW + YW;

    logic [23:0] mem_a [2**AW];
    logic [23:0] mem_b [2**AW];

    logic          wr_en;
    logic [31:0]   wx, wy;
    logic [AW-1:0] wr_addr;
    logic [23:0]   wr_data;

    logic          r_vld, r_smp;
    logic [23:0]   r_t00, r_t10, r_t01, r_t11;
    logic [COORD_FRAC_BITS-1:0] r_dx, r_dy;

    always_comb begin
        wx      = 32'(i_texel.x);
        wy      = 32'(i_texel.y);
        wr_en   = i_en && i_vld && (i_sample == MODE_WRITE)
                  && (wx < 32'(MAX_WIDTH)) && (wy < 32'(MAX_HEIGHT));
        wr_addr = {wy[YW-1:0], wx[XW-1:0]};
        wr_data = {i_texel.red, i_texel.green, i_texel.blue};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (i_en) begin
            r_t00 <= mem_a[{i_y0, i_x0}];
            r_t10 <= mem_a[{i_y0, i_x1}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_b[wr_addr] <= wr_data;
        end
        if (i_en) begin
            r_t01 <= mem_b[{i_y1, i_x0}];
            r_t11 <= mem_b[{i_y1, i_x1}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_smp <= i_sample;
            r_dx  <= i_dx;
            r_dy  <= i_dy;
        end
    end

    assign o_vld    = r_vld;
    assign o_sample = r_smp;
    assign o_t00    = r_t00;
    assign o_t10    = r_t10;
    assign o_t01    = r_t01;
    assign o_t11    = r_t11;
    assign o_dx     = r_dx;
    assign o_dy     = r_dy;

endmodule

// ===== sv/tsb_blend.sv =====
// Blend stages: weights, per-channel products, sum and rounding.
// Depends on tsb_pkg.
`timescale 1ns / 1ps

module tsb_blend #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic                       i_sample,
    input  logic [23:0]                i_t00,
    input  logic [23:0]                i_t10,
    input  logic [23:0]                i_t01,
    input  logic [23:0]                i_t11,
    input  logic [COORD_FRAC_BITS-1:0] i_dx,
    input  logic [COORD_FRAC_BITS-1:0] i_dy,
    output logic                       o_vld,
    output logic [15:0]                o_red,
    output logic [15:0]                o_green,
    output logic [15:0]                o_blue
);
    import tsb_pkg::*;

    localparam int CF = COORD_FRAC_BITS;
    localparam int WW = 2 * CF + 2;
    localparam int PW = WW + 8;
    localparam logic [CF:0] ONE = (CF+1)'(1) << CF;
    localparam logic [PW-1:0] RND = PW'(1) << (2 * CF - 9);

    logic          r_c_vld, r_c_smp;
    logic [WW-1:0] r_w [4];
    logic [23:0]   r_c_t [4];

    logic          r_d_vld, r_d_smp;
    logic [PW-1:0] r_p [3][4];

    logic          r_e_vld;
    logic [15:0]   r_o [3];

    logic [CF:0]   ex, ey, nx, ny;
    logic [PW-1:0] sum [3];

    always_comb begin
        ex = (CF+1)'(i_dx);
        ey = (CF+1)'(i_dy);
        nx = ONE - ex;
        ny = ONE - ey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= i_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld && (r_d_smp == MODE_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_smp  <= i_sample;
            r_w[0]   <= WW'(nx) * WW'(ny);
            r_w[1]   <= WW'(ex) * WW'(ny);
            r_w[2]   <= WW'(nx) * WW'(ey);
            r_w[3]   <= WW'(ex) * WW'(ey);
            r_c_t[0] <= i_t00;
            r_c_t[1] <= i_t10;
            r_c_t[2] <= i_t01;
            r_c_t[3] <= i_t11;
            r_d_smp  <= r_c_smp;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 4; j++) begin
                    r_p[k][j] <= PW'(r_c_t[j][16-8*k +: 8]) * PW'(r_w[j]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_o[k] <= 16'(sum[k] >> (2 * CF - 8));
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = r_p[k][0] + r_p[k][1] + r_p[k][2] + r_p[k][3] + RND;
        end
    end

    assign o_vld   = r_e_vld;
    assign o_red   = r_o[0];
    assign o_green = r_o[1];
    assign o_blue  = r_o[2];

endmodule

// ===== sv/texture_sampler_bilinear.sv =====
// Bilinear / nearest texture sampler, top level.
// One item per cycle while the output is not stalled; write items flow through
// and give no result. Throughput is set by the six-stage pipeline with two
// dual-read texel copies. Synchronous active-low reset clears valid flags and
// sets configuration to 256x256, clamp, nearest. Texel store contents are
// undefined until written. Depends on tsb_pkg, tsb_coord, tsb_store, tsb_blend.
`timescale 1ns / 1ps

module texture_sampler_bilinear #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [7:0]                   i_texel_x,
    input  logic [7:0]                   i_texel_y,
    input  logic [7:0]                   i_red_in,
    input  logic [7:0]                   i_green_in,
    input  logic [7:0]                   i_blue_in,
    input  logic signed [23:0]           i_u_coord,
    input  logic signed [23:0]           i_v_coord,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [15:0]                  o_red_out,
    output logic [15:0]                  o_green_out,
    output logic [15:0]                  o_blue_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsb_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CF = COORD_FRAC_BITS;

    t_cfg   r_cfg;
    t_texel in_texel, c_texel;
    logic   en;

    logic          c_vld, c_smp;
    logic [XW-1:0] c_x0, c_x1;
    logic [YW-1:0] c_y0, c_y1;
    logic [CF-1:0] c_dx, c_dy, s_dx, s_dy;
    logic          s_vld, s_smp;
    logic [23:0]   s_t00, s_t10, s_t01, s_t11;

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_width    <= SIZE_RESET;
            r_cfg.tex_height   <= SIZE_RESET;
            r_cfg.address_mode <= 1'b0;
            r_cfg.filter_mode  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEX_WIDTH:    r_cfg.tex_width    <= i_cfg_data;
                CFG_TEX_HEIGHT:   r_cfg.tex_height   <= i_cfg_data;
                CFG_ADDRESS_MODE: r_cfg.address_mode <= i_cfg_data[0];
                CFG_FILTER_MODE:  r_cfg.filter_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        in_texel.x     = i_texel_x;
        in_texel.y     = i_texel_y;
        in_texel.red   = i_red_in;
        in_texel.green = i_green_in;
        in_texel.blue  = i_blue_in;
    end

    tsb_coord #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .COORD_FRAC_BITS(COORD_FRAC_BITS), .XW(XW), .YW(YW)
    ) u_coord (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(i_valid), .i_sample(i_mode), .i_texel(in_texel),
        .i_u(i_u_coord), .i_v(i_v_coord), .i_cfg(r_cfg),
        .o_vld(c_vld), .o_sample(c_smp), .o_texel(c_texel),
        .o_x0(c_x0), .o_x1(c_x1), .o_y0(c_y0), .o_y1(c_y1),
        .o_dx(c_dx), .o_dy(c_dy)
    );

    tsb_store #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .COORD_FRAC_BITS(COORD_FRAC_BITS), .XW(XW), .YW(YW)
    ) u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(c_vld), .i_sample(c_smp), .i_texel(c_texel),
        .i_x0(c_x0), .i_x1(c_x1), .i_y0(c_y0), .i_y1(c_y1),
        .i_dx(c_dx), .i_dy(c_dy),
        .o_vld(s_vld), .o_sample(s_smp),
        .o_t00(s_t00), .o_t10(s_t10), .o_t01(s_t01), .o_t11(s_t11),
        .o_dx(s_dx), .o_dy(s_dy)
    );

    tsb_blend #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_blend (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(s_vld), .i_sample(s_smp),
        .i_t00(s_t00), .i_t10(s_t10), .i_t01(s_t01), .i_t11(s_t11),
        .i_dx(s_dx), .i_dy(s_dy),
        .o_vld(o_valid), .o_red(o_red_out), .o_green(o_green_out), .o_blue(o_blue_out)
    );

endmodule

// ===== tb/sv/tsb_checker.sv =====
// Result checker for the bilinear texture sampler: predicts each sample from
// observed input and configuration transfers and compares results. Depends on tsb_pkg.
`timescale 1ns / 1ps

module tsb_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_rdy,
    input  logic               i_mode,
    input  logic [7:0]         i_tx,
    input  logic [7:0]         i_ty,
    input  logic [7:0]         i_r,
    input  logic [7:0]         i_g,
    input  logic [7:0]         i_b,
    input  logic signed [23:0] i_u,
    input  logic signed [23:0] i_v,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [15:0]        i_r_out,
    input  logic [15:0]        i_g_out,
    input  logic [15:0]        i_b_out,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [tsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_samples
);
    import tsb_pkg::*;

    localparam longint ONE = 64'd1 << 16;

    logic [23:0] texels [0:65535];
    t_cfg        cfg;
    logic [47:0] colour_q[$];

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
        o_errors++;
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, exp);
    endtask

    function automatic longint wrap_coord(input logic signed [23:0] c);
        longint cv;
        cv = c;
        if (cfg.address_mode) return cv & (ONE - 1);
        if (cv < 0) return 0;
        if (cv > ONE) return ONE;
        return cv;
    endfunction

    function automatic longint eff(input logic [8:0] s);
        if (s == 0) return 1;
        if (s > 256) return 256;
        return s;
    endfunction

    function automatic logic [47:0] sample_colour(input logic signed [23:0] u,
                                                  input logic signed [23:0] v);
        longint w, h, su, sv, p, q, p1, q1, dx, dy, acc;
        longint wt[4];
        logic [23:0] t[4];
        logic [47:0] res;
        w = eff(cfg.tex_width);
        h = eff(cfg.tex_height);
        su = wrap_coord(u) * w;
        sv = wrap_coord(v) * h;
        if (!cfg.filter_mode) begin
            p = (su + ONE / 2) >> 16;
            q = (sv + ONE / 2) >> 16;
            if (p > w - 1) p = w - 1;
            if (q > h - 1) q = h - 1;
            t[0] = texels[q * 256 + p];
            return {8'(t[0][23:16]), 8'd0, 8'(t[0][15:8]), 8'd0, 8'(t[0][7:0]), 8'd0};
        end
        p = su >> 16;
        q = sv >> 16;
        dx = su & (ONE - 1);
        dy = sv & (ONE - 1);
        if (p > w - 1) begin p = w - 1; dx = 0; end
        if (q > h - 1) begin q = h - 1; dy = 0; end
        p1 = (p + 1 > w - 1) ? 0 : p + 1;
        q1 = (q + 1 > h - 1) ? 0 : q + 1;
        wt[0] = (ONE - dx) * (ONE - dy);
        wt[1] = dx * (ONE - dy);
        wt[2] = (ONE - dx) * dy;
        wt[3] = dx * dy;
        t[0] = texels[q * 256 + p];
        t[1] = texels[q * 256 + p1];
        t[2] = texels[q1 * 256 + p];
        t[3] = texels[q1 * 256 + p1];
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int n = 0; n < 4; n++)
                acc += longint'((t[n] >> (16 - 8 * k)) & 8'hff) * wt[n];
            acc = (acc + (64'd1 << 23)) >> 24;
            res[47 - 16 * k -: 16] = acc[15:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        logic [47:0] exp;
        if (!i_rst_n) begin
            cfg <= '{tex_width: SIZE_RESET, tex_height: SIZE_RESET,
                     address_mode: 1'b0, filter_mode: 1'b0};
            colour_q.delete();
            o_errors <= 0;
            o_samples <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEX_WIDTH:    cfg.tex_width    <= i_cfg_data;
                    CFG_TEX_HEIGHT:   cfg.tex_height   <= i_cfg_data;
                    CFG_ADDRESS_MODE: cfg.address_mode <= i_cfg_data[0];
                    CFG_FILTER_MODE:  cfg.filter_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (colour_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: result transfer with nothing expected", $realtime);
                end else begin
                    exp = colour_q.pop_front();
                    if (i_r_out !== exp[47:32]) report("red", i_r_out, exp[47:32]);
                    if (i_g_out !== exp[31:16]) report("green", i_g_out, exp[31:16]);
                    if (i_b_out !== exp[15:0]) report("blue", i_b_out, exp[15:0]);
                    o_samples++;
                end
            end
            if (i_valid && i_rdy) begin
                if (i_mode == MODE_WRITE)
                    texels[{i_ty, i_tx}] = {i_r, i_g, i_b};
                else
                    colour_q = {colour_q, sample_colour(i_u, i_v)};
            end
        end
    end

    assign o_pending = colour_q.size();

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for texture_sampler_bilinear: drives texel writes, samples and
// register writes with random gaps and stalls. Depends on tsb_pkg, tsb_checker.
`timescale 1ns / 1ps

module tb_top;
    import tsb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
    logic mode = 1'b0;
    logic [7:0] tx = '0, ty = '0, rr = '0, gg = '0, bb = '0;
    logic signed [23:0] uc = '0, vc = '0;
    logic [15:0] r_out, g_out, b_out;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int errors, pending, samples;
    int hold_off = 0;

    always #5 i_clk = ~i_clk;

    texture_sampler_bilinear dut (
        .i_clk, .i_rst_n, .i_valid(in_valid), .o_ready(in_ready), .i_mode(mode),
        .i_texel_x(tx), .i_texel_y(ty), .i_red_in(rr), .i_green_in(gg), .i_blue_in(bb),
        .i_u_coord(uc), .i_v_coord(vc), .o_valid(out_valid), .i_ready(out_ready),
        .o_red_out(r_out), .o_green_out(g_out), .o_blue_out(b_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    tsb_checker chk (
        .i_clk, .i_rst_n, .i_valid(in_valid), .i_rdy(in_ready), .i_mode(mode),
        .i_tx(tx), .i_ty(ty), .i_r(rr), .i_g(gg), .i_b(bb), .i_u(uc), .i_v(vc),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_r_out(r_out), .i_g_out(g_out), .i_b_out(b_out),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_samples(samples)
    );

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off > 0) begin
                out_ready <= 1'b0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send(input logic m, input logic [7:0] x, input logic [7:0] y,
                        input logic [23:0] col, input logic [23:0] u,
                        input logic [23:0] v, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        tx <= x; ty <= y;
        {rr, gg, bb} <= col;
        uc <= u; vc <= v;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic write_texel(input int x, input int y, input bit no_gap);
        send(MODE_WRITE, x[7:0], y[7:0], 24'($urandom), 24'($urandom), 24'($urandom),
             no_gap);
    endtask

    task automatic sample_at(input logic [23:0] u, input logic [23:0] v, input bit no_gap);
        send(MODE_SAMPLE, 8'($urandom), 8'($urandom), 24'($urandom), u, v, no_gap);
    endtask

    // drain: idle sender, all results in, then allow the pipeline to settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'h010000;
            2: return 24'($urandom_range(0, 24'h00ffff));
            default: return 24'($urandom_range(0, 24'h010000));
        endcase
    endfunction

    // fill the whole area in use so no unwritten texel is read
    task automatic fill(input int w, input int h);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                write_texel(x, y, $urandom_range(0, 3) != 0);
    endtask

    task automatic setup(input int w, input int h, input bit am, input bit fm);
        set_reg(CFG_TEX_WIDTH, w);
        set_reg(CFG_TEX_HEIGHT, h);
        set_reg(CFG_ADDRESS_MODE, am);
        set_reg(CFG_FILTER_MODE, fm);
    endtask

    initial begin
        int w, h;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small texture, clamp and repeat, both filters, edge coordinates
        setup(2, 2, 1'b0, 1'b0);
        send(MODE_WRITE, 8'd0, 8'd0, 24'hffffff, '0, '0, 1'b0);
        send(MODE_WRITE, 8'd1, 8'd0, 24'h000000, '0, '0, 1'b0);
        send(MODE_WRITE, 8'd0, 8'd1, 24'h80ff01, '0, '0, 1'b0);
        send(MODE_WRITE, 8'd1, 8'd1, 24'h7f00fe, '0, '0, 1'b0);
        // write outside the texture area in use but inside the store
        send(MODE_WRITE, 8'd255, 8'd255, 24'h123456, '0, '0, 1'b0);
        for (int f = 0; f < 2; f++) begin
            drain();
            setup(2, 2, 1'b0, f[0]);
            sample_at(24'h000000, 24'h000000, 1'b0);
            sample_at(24'h010000, 24'h010000, 1'b0);
            sample_at(24'h800000, 24'h7fffff, 1'b0);
            sample_at(24'h008000, 24'h007fff, 1'b0);
            sample_at(24'hffffff, 24'h00ffff, 1'b0);
            drain();
            setup(2, 2, 1'b1, f[0]);
            sample_at(24'h018000, 24'hff4000, 1'b0);
            sample_at(24'h7fffff, 24'h800000, 1'b0);
        end
        drain();
        // size 0 acts as 1 (all used texels are written)
        setup(0, 0, 1'b0, 1'b1);
        sample_at(24'h00c000, 24'h010000, 1'b0);
        drain();
        set_reg(8'd200, 9'h1ff);

        // random phases over several sizes and modes
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: begin w = 1; h = 1; end
                1: begin w = 256; h = 1; end
                2: begin w = 1; h = 32; end
                default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
            endcase
            setup(w, h, ph[0], ph[1]);
            fill(w, h);
            for (int n = 0; n < 25; n++) begin
                if (ph == 4 && n == 5) hold_off = 60;
                if ($urandom_range(0, 4) == 0)
                    write_texel($urandom_range(0, w - 1), $urandom_range(0, h - 1), 1'b0);
                else
                    sample_at(rand_coord(), rand_coord(), ph == 4);
                if (ph == 6 && n == 20) begin
                    in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end
        drain();
        // oversized registers act as 256x256; keep reads inside the written corner
        setup(511, 300, 1'b0, 1'b1);
        fill(4, 4);
        for (int n = 0; n < 20; n++)
            sample_at(24'($urandom_range(0, 24'h000200)), 24'($urandom_range(0, 24'h000200)),
                      1'b0);
        drain();

        $display("Run covered both filters and address modes over texture sizes 0..511,");
        $display("with %0d sampled results checked.", samples);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
